@@ design/llca_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the life-like cellular automaton block.
// No dependencies; imported by the interfaces, the cell chain and the top level.
package llca_pkg;

  localparam int OP_W       = 2;
  localparam int FIELD_W    = 6;
  localparam int SIZE_W     = 7;
  localparam int MASK_W     = 9;
  localparam int NBR_W      = 4;
  localparam int LIVE_W     = 13;
  localparam int GEN_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [LIVE_W-1:0] LIVE_SAT    = 13'd8191;
  localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
  localparam logic [SIZE_W-1:0] SIZE_RST    = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic {
    RES_READ = 1'b0,
    RES_STEP = 1'b1
  } res_kind_t;

  typedef enum logic {
    BND_WRAP = 1'b0,
    BND_DEAD = 1'b1
  } bnd_t;

  typedef enum logic {
    SHAPE_MOORE = 1'b0,
    SHAPE_VN    = 1'b1
  } shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUNDARY = 3'd0,
    CFG_SHAPE    = 3'd1,
    CFG_BIRTH    = 3'd2,
    CFG_SURVIVE  = 3'd3,
    CFG_WIDTH    = 3'd4,
    CFG_HEIGHT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_STEP,
    ST_COPY_RD,
    ST_COPY_LD,
    ST_COPY_SH
  } state_t;

  typedef struct packed {
    bnd_t              boundary;
    shape_t            shape;
    logic [MASK_W-1:0] birth;
    logic [MASK_W-1:0] survive;
  } rule_t;

  typedef struct packed {
    logic shift_row;
    logic load_sh;
    logic shift_sh;
  } cell_ctl_t;

endpackage

@@ design/llca_if.sv @@
`timescale 1ns / 1ps
// Request, result and configuration channels of the cellular automaton block.
// Depends on llca_pkg for field widths.
interface llca_req_if import llca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FIELD_W-1:0] col;
  logic [FIELD_W-1:0] row;
  logic               cell_in;

  modport source (output valid, output op, output col, output row, output cell_in,
                  input ready);
  modport sink (input valid, input op, input col, input row, input cell_in,
                output ready);
endinterface

interface llca_rsp_if import llca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic              cell_out;
  logic [LIVE_W-1:0] live_total;
  logic [GEN_W-1:0]  gen_count;

  modport source (output valid, output result_kind, output cell_out, output live_total,
                  output gen_count, input ready);
  modport sink (input valid, input result_kind, input cell_out, input live_total,
                input gen_count, output ready);
endinterface

interface llca_cfg_if import llca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/llca_cell.sv @@
`timescale 1ns / 1ps
// One column cell: three-row window, neighbor count, rule lookup and a count shift stage.
// Depends on llca_pkg.
module llca_cell import llca_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  rule_t     rule,
  input  logic      in_use,
  input  logic      row_bit,
  input  logic      sh_bit,
  input  logic      sh_right,
  input  logic [2:0] lwin,
  input  logic [2:0] rwin,
  output logic [2:0] win,
  output logic      next_bit,
  output logic      sh_out
);

  logic              up;
  logic              mid;
  logic              dn;
  logic              sh;
  logic [NBR_W-1:0]  nbr;
  logic [MASK_W-1:0] mask;

  always_ff @(posedge clk) begin
    if (ctl.shift_row) begin
      up  <= mid;
      mid <= dn;
      dn  <= row_bit;
    end
    if (ctl.load_sh) begin
      sh <= sh_bit;
    end else if (ctl.shift_sh) begin
      sh <= sh_right;
    end
  end

  assign win    = {up, mid, dn};
  assign sh_out = sh;

  always_comb begin
    if (rule.shape == SHAPE_VN) begin
      nbr = NBR_W'(lwin[1]) + NBR_W'(rwin[1]) + NBR_W'(up) + NBR_W'(dn);
    end else begin
      nbr = NBR_W'(lwin[2]) + NBR_W'(lwin[1]) + NBR_W'(lwin[0]) +
            NBR_W'(rwin[2]) + NBR_W'(rwin[1]) + NBR_W'(rwin[0]) +
            NBR_W'(up) + NBR_W'(dn);
    end
    mask     = mid ? rule.survive : rule.birth;
    next_bit = in_use ? mask[nbr] : mid;
  end

endmodule

@@ design/llca_row.sv @@
`timescale 1ns / 1ps
// Row of column cells; resolves the left and right edges for wrap or dead borders.
// Depends on llca_pkg and llca_cell.
module llca_row import llca_pkg::*; #(
  parameter int MAX_COLS = 64,
  localparam int UC_W = $clog2(MAX_COLS + 1)
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  rule_t               rule,
  input  logic [UC_W-1:0]     used_cols,
  input  logic [MAX_COLS-1:0] row_in,
  input  logic [MAX_COLS-1:0] sh_in,
  output logic [MAX_COLS-1:0] next_row,
  output logic                sh_out
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [2:0]       win [MAX_COLS];
  logic             sh  [MAX_COLS];
  logic [UC_W-1:0]  last_ext;
  logic [COL_W-1:0] last;
  logic [2:0]       last_win;
  logic             wrap;

  assign last_ext = used_cols - UC_W'(1);
  assign last     = last_ext[COL_W-1:0];
  assign last_win = win[last];
  assign wrap     = (rule.boundary == BND_WRAP);
  assign sh_out   = sh[0];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    logic [2:0] lw;
    logic [2:0] rw;
    logic       sh_r;
    logic       use_c;

    assign use_c = (UC_W'(c) < used_cols);

    if (c == 0) begin : g_left_edge
      assign lw = wrap ? last_win : 3'b000;
    end else begin : g_left
      assign lw = win[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_edge
      assign rw   = wrap ? win[0] : 3'b000;
      assign sh_r = 1'b0;
    end else begin : g_right
      assign rw   = (last == COL_W'(c)) ? (wrap ? win[0] : 3'b000) : win[c+1];
      assign sh_r = sh[c+1];
    end

    llca_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .rule     (rule),
      .in_use   (use_c),
      .row_bit  (row_in[c]),
      .sh_bit   (sh_in[c]),
      .sh_right (sh_r),
      .lwin     (lw),
      .rwin     (rw),
      .win      (win[c]),
      .next_bit (next_row[c]),
      .sh_out   (sh[c])
    );
  end

endmodule

@@ design/life_like_ca_generation.sv @@
`timescale 1ns / 1ps
// Top level of the life-like cellular automaton: grid memories, sequencer, result register.
// Depends on llca_pkg, the llca interfaces and llca_row.
//
// Usage: requests arrive on req (op, col, row, cell_in), results leave on rsp,
// rule and grid size are set through cfg (always ready, written while idle).
// A write request gives no result. A read request reads the grid memory, then
// loads its result into the output register once that register is free. A step
// request sweeps the grid row by row through a chain of one cell per column: it
// computes the next rows into the second buffer, then copies each row back and
// counts its live cells one bit per cycle along the chain, and then posts the
// result. An empty grid step skips the sweep and posts its result directly.
// One request is worked at a time; a new one is taken while the previous result
// still waits in the output register. A stalled receiver holds the result and,
// once the next result is ready, holds the block until the register frees up.
// After reset the grid is cleared one row per cycle while no request is taken;
// configuration returns to its defaults at once.
module life_like_ca_generation import llca_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input logic      clk,
  input logic      rst,
  llca_req_if.sink   req,
  llca_rsp_if.source rsp,
  llca_cfg_if.sink   cfg
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int UC_W  = $clog2(MAX_COLS + 1);
  localparam int UR_W  = $clog2(MAX_ROWS + 1);
  localparam int CMP_A = (UC_W > UR_W) ? UC_W : UR_W;
  localparam int CMP_W = (CMP_A > SIZE_W) ? CMP_A : SIZE_W;
  localparam int SEQ_W = $clog2(MAX_ROWS + 4);

  bnd_t              boundary;
  shape_t            shape;
  logic [MASK_W-1:0] birth;
  logic [MASK_W-1:0] survive;
  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  rule_t             rule;

  logic [CMP_W-1:0] uc_cmp;
  logic [CMP_W-1:0] ur_cmp;
  logic [UC_W-1:0]  used_cols;
  logic [UC_W-1:0]  uc_last;
  logic [SEQ_W-1:0] h_seq;
  logic [SEQ_W-1:0] h_m1;
  logic [SEQ_W-1:0] h_p1;
  logic [SEQ_W-1:0] h_p2;
  logic [SEQ_W-1:0] h_p3;
  logic             grid_empty;
  logic             dead;

  logic [CMP_W-1:0] col_ext;
  logic [CMP_W-1:0] row_ext;
  logic [COL_W-1:0] col_idx;
  logic [ROW_W-1:0] row_idx;
  logic             req_in_rng;

  state_t            state;
  state_t            state_next;
  logic [SEQ_W-1:0]  cnt;
  logic [SEQ_W-1:0]  cnt_next;
  logic [SEQ_W-1:0]  cnt_m1;
  logic [SEQ_W-1:0]  cnt_m4;
  logic [ROW_W-1:0]  cnt_row;
  logic [UC_W-1:0]   shc;
  logic [UC_W-1:0]   shc_next;
  logic [LIVE_W-1:0] live;
  logic [LIVE_W-1:0] live_next;
  logic [GEN_W-1:0]  gen;
  logic [GEN_W-1:0]  gen_next;
  logic              feed_zero;
  logic              feed_zero_next;
  res_kind_t         res_kind;
  res_kind_t         res_kind_next;
  logic [COL_W-1:0]  col_q;
  logic [COL_W-1:0]  col_q_next;
  logic              in_rng_q;
  logic              in_rng_q_next;
  logic              out_load;

  logic              out_valid;
  res_kind_t         out_kind;
  logic              out_cell;
  logic [LIVE_W-1:0] out_live;
  logic [GEN_W-1:0]  out_gen;

  logic [MAX_COLS-1:0] cell_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] next_mem [MAX_ROWS];
  logic                c_we;
  logic [ROW_W-1:0]    c_waddr;
  logic [MAX_COLS-1:0] c_wmask;
  logic [MAX_COLS-1:0] c_wdata;
  logic                c_re;
  logic [ROW_W-1:0]    c_raddr;
  logic [MAX_COLS-1:0] rd_word;
  logic                n_we;
  logic [ROW_W-1:0]    n_waddr;
  logic                n_re;
  logic [ROW_W-1:0]    n_raddr;
  logic [MAX_COLS-1:0] nx_word;

  cell_ctl_t           ctl;
  logic [MAX_COLS-1:0] row_in;
  logic [MAX_COLS-1:0] next_row;
  logic                sh_out;

  assign rule = '{boundary: boundary, shape: shape, birth: birth, survive: survive};
  assign dead = (boundary == BND_DEAD);

  assign uc_cmp = (CMP_W'(grid_width) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
                                                          : CMP_W'(grid_width);
  assign ur_cmp = (CMP_W'(grid_height) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                           : CMP_W'(grid_height);
  assign used_cols  = UC_W'(uc_cmp);
  assign uc_last    = used_cols - UC_W'(1);
  assign h_seq      = SEQ_W'(ur_cmp);
  assign h_m1       = h_seq - SEQ_W'(1);
  assign h_p1       = h_seq + SEQ_W'(1);
  assign h_p2       = h_seq + SEQ_W'(2);
  assign h_p3       = h_seq + SEQ_W'(3);
  assign grid_empty = (uc_cmp == '0) || (ur_cmp == '0);

  assign col_ext    = CMP_W'(req.col);
  assign row_ext    = CMP_W'(req.row);
  assign col_idx    = col_ext[COL_W-1:0];
  assign row_idx    = row_ext[ROW_W-1:0];
  assign req_in_rng = (col_ext < uc_cmp) && (row_ext < ur_cmp);

  assign cnt_m1  = cnt - SEQ_W'(1);
  assign cnt_m4  = cnt - SEQ_W'(4);
  assign cnt_row = cnt[ROW_W-1:0];

  assign row_in = feed_zero ? '0 : rd_word;

  assign req.ready       = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.cell_out    = out_cell;
  assign rsp.live_total  = out_live;
  assign rsp.gen_count   = out_gen;

  llca_row #(.MAX_COLS(MAX_COLS)) u_row (
    .clk       (clk),
    .ctl       (ctl),
    .rule      (rule),
    .used_cols (used_cols),
    .row_in    (row_in),
    .sh_in     (nx_word),
    .next_row  (next_row),
    .sh_out    (sh_out)
  );

  always_ff @(posedge clk) begin
    if (c_we) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        if (c_wmask[c]) begin
          cell_mem[c_waddr][c] <= c_wdata[c];
        end
      end
    end
    if (c_re) begin
      rd_word <= cell_mem[c_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      next_mem[n_waddr] <= next_row;
    end
    if (n_re) begin
      nx_word <= next_mem[n_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary    <= BND_WRAP;
      shape       <= SHAPE_MOORE;
      birth       <= BIRTH_RST;
      survive     <= SURVIVE_RST;
      grid_width  <= SIZE_RST;
      grid_height <= SIZE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BOUNDARY: boundary    <= bnd_t'(cfg.data[0]);
        CFG_SHAPE:    shape       <= shape_t'(cfg.data[0]);
        CFG_BIRTH:    birth       <= cfg.data;
        CFG_SURVIVE:  survive     <= cfg.data;
        CFG_WIDTH:    grid_width  <= cfg.data[SIZE_W-1:0];
        CFG_HEIGHT:   grid_height <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      shc       <= '0;
      live      <= '0;
      gen       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      shc   <= shc_next;
      live  <= live_next;
      gen   <= gen_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    feed_zero <= feed_zero_next;
    res_kind  <= res_kind_next;
    col_q     <= col_q_next;
    in_rng_q  <= in_rng_q_next;
    if (out_load) begin
      out_kind <= res_kind;
      out_cell <= (res_kind == RES_READ) ? (rd_word[col_q] & in_rng_q) : 1'b0;
      out_live <= (res_kind == RES_STEP) ? live : '0;
      out_gen  <= (res_kind == RES_STEP) ? gen : '0;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    shc_next       = shc;
    live_next      = live;
    gen_next       = gen;
    feed_zero_next = feed_zero;
    res_kind_next  = res_kind;
    col_q_next     = col_q;
    in_rng_q_next  = in_rng_q;
    out_load       = 1'b0;
    c_we           = 1'b0;
    c_waddr        = cnt_row;
    c_wmask        = '0;
    c_wdata        = '0;
    c_re           = 1'b0;
    c_raddr        = row_idx;
    n_we           = 1'b0;
    n_waddr        = cnt_m4[ROW_W-1:0];
    n_re           = 1'b0;
    n_raddr        = cnt_row;
    ctl            = '0;

    case (state)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_wmask = '1;
        if (cnt == SEQ_W'(MAX_ROWS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + SEQ_W'(1);
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          case (req.op)
            OP_WRITE: begin
              if (req_in_rng) begin
                c_we             = 1'b1;
                c_waddr          = row_idx;
                c_wmask[col_idx] = 1'b1;
                c_wdata          = {MAX_COLS{req.cell_in}};
              end
            end
            OP_READ: begin
              c_re          = 1'b1;
              res_kind_next = RES_READ;
              col_q_next    = col_idx;
              in_rng_q_next = req_in_rng;
              state_next    = ST_PUSH;
            end
            OP_STEP: begin
              res_kind_next = RES_STEP;
              live_next     = '0;
              cnt_next      = '0;
              if (grid_empty) begin
                gen_next   = gen + GEN_W'(1);
                state_next = ST_PUSH;
              end else begin
                state_next = ST_STEP;
              end
            end
            default: ;
          endcase
        end
      end

      ST_PUSH: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_STEP: begin
        // fetch wrap row, rows 0..h-1, wrap row; each fetched row passes the read register, then enters the window
        if (cnt <= h_p1) begin
          c_re = 1'b1;
          if (cnt == '0) begin
            c_raddr = h_m1[ROW_W-1:0];
          end else if (cnt == h_p1) begin
            c_raddr = '0;
          end else begin
            c_raddr = cnt_m1[ROW_W-1:0];
          end
          feed_zero_next = dead && ((cnt == '0) || (cnt == h_p1));
        end
        if ((cnt >= SEQ_W'(1)) && (cnt <= h_p2)) begin
          ctl.shift_row = 1'b1;
        end
        if (cnt >= SEQ_W'(4)) begin
          n_we = 1'b1;
        end
        if (cnt == h_p3) begin
          cnt_next   = '0;
          state_next = ST_COPY_RD;
        end else begin
          cnt_next = cnt + SEQ_W'(1);
        end
      end

      ST_COPY_RD: begin
        n_re       = 1'b1;
        state_next = ST_COPY_LD;
      end

      ST_COPY_LD: begin
        c_we        = 1'b1;
        c_wmask     = '1;
        c_wdata     = nx_word;
        ctl.load_sh = 1'b1;
        shc_next    = '0;
        state_next  = ST_COPY_SH;
      end

      ST_COPY_SH: begin
        ctl.shift_sh = 1'b1;
        if (sh_out && (live != LIVE_SAT)) begin
          live_next = live + LIVE_W'(1);
        end
        if (shc == uc_last) begin
          shc_next = '0;
          if (cnt == h_m1) begin
            gen_next   = gen + GEN_W'(1);
            state_next = ST_PUSH;
          end else begin
            cnt_next   = cnt + SEQ_W'(1);
            state_next = ST_COPY_RD;
          end
        end else begin
          shc_next = shc + UC_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_step_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.op == OP_STEP) |=> state != ST_IDLE)
    else $error("step request did not start a generation");

  a_push_posts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) && (!out_valid || rsp.ready) |=> out_valid && (state == ST_IDLE))
    else $error("pending result not posted to the output register");

  a_gen_advance: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (gen != $past(gen)) |->
      (gen == $past(gen) + GEN_W'(1)) &&
      (($past(state) == ST_COPY_SH) || ($past(state) == ST_IDLE)))
    else $error("generation counter moved outside a generation end");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for life_like_ca_generation: cell writes, reads and generation
// steps under many rules and grid sizes, checked against a grid predictor kept in the bench.
// Depends on llca_pkg, the llca interfaces and the design sources.
module testbench;
  import llca_pkg::*;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    res_kind_t         kind;
    logic              cell_bit;
    logic [LIVE_W-1:0] live;
    logic [GEN_W-1:0]  gen;
  } ca_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  llca_req_if req_ch ();
  llca_rsp_if rsp_ch ();
  llca_cfg_if cfg_ch ();

  life_like_ca_generation #(.MAX_COLS(GRID_COLS), .MAX_ROWS(GRID_ROWS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  bit                grid [GRID_ROWS][GRID_COLS];
  logic [GEN_W-1:0]  gen_counter;
  bnd_t              boundary;
  shape_t            shape;
  logic [MASK_W-1:0] birth;
  logic [MASK_W-1:0] survive;
  logic [SIZE_W-1:0] grid_w;
  logic [SIZE_W-1:0] grid_h;

  ca_result_t due_results[$];
  int error_count = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic report_mismatch(string field, logic [GEN_W-1:0] got, logic [GEN_W-1:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
    error_count++;
  endtask

  function automatic int span(logic [SIZE_W-1:0] sz, int lim);
    return (sz > lim) ? lim : int'(sz);
  endfunction

  function automatic logic [LIVE_W-1:0] evolve_grid();
    bit nxt [GRID_ROWS][GRID_COLS];
    int w, h, n, nr, nc, live;
    logic [MASK_W-1:0] mask;
    w = span(grid_w, GRID_COLS);
    h = span(grid_h, GRID_ROWS);
    live = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr == 0 && dc == 0) || (shape == SHAPE_VN && dr != 0 && dc != 0)) continue;
            nr = r + dr;
            nc = c + dc;
            if (boundary == BND_WRAP) begin
              if (nr < 0) nr += h;
              if (nr >= h) nr -= h;
              if (nc < 0) nc += w;
              if (nc >= w) nc -= w;
            end else if (nr < 0 || nr >= h || nc < 0 || nc >= w) begin
              continue;
            end
            n += grid[nr][nc];
          end
        end
        mask = grid[r][c] ? survive : birth;
        nxt[r][c] = mask[n];
      end
    end
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        grid[r][c] = nxt[r][c];
        live += nxt[r][c];
      end
    end
    return (live > LIVE_SAT) ? LIVE_SAT : LIVE_W'(live);
  endfunction

  function automatic void apply_ca_request(logic [OP_W-1:0] op, logic [FIELD_W-1:0] col,
                                           logic [FIELD_W-1:0] row, logic cell_in);
    ca_result_t res;
    int w, h;
    w = span(grid_w, GRID_COLS);
    h = span(grid_h, GRID_ROWS);
    res = '{kind: RES_READ, cell_bit: 1'b0, live: '0, gen: '0};
    case (op)
      OP_WRITE: begin
        if (col < w && row < h) grid[row][col] = cell_in;
      end
      OP_READ: begin
        if (col < w && row < h) res.cell_bit = grid[row][col];
        due_results.push_back(res);
      end
      OP_STEP: begin
        res.kind = RES_STEP;
        res.live = evolve_grid();
        gen_counter = gen_counter + 1'b1;
        res.gen = gen_counter;
        due_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    ca_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request pending", GEN_W'(rsp_ch.result_kind), '0);
      end else begin
        want = due_results.pop_front();
        if (rsp_ch.result_kind !== want.kind)
          report_mismatch("result_kind", GEN_W'(rsp_ch.result_kind), GEN_W'(want.kind));
        if (rsp_ch.cell_out !== want.cell_bit)
          report_mismatch("cell_out", GEN_W'(rsp_ch.cell_out), GEN_W'(want.cell_bit));
        if (rsp_ch.live_total !== want.live)
          report_mismatch("live_total", GEN_W'(rsp_ch.live_total), GEN_W'(want.live));
        if (rsp_ch.gen_count !== want.gen)
          report_mismatch("gen_count", rsp_ch.gen_count, want.gen);
      end
    end
  end

  task automatic send_req(logic [OP_W-1:0] op, logic [FIELD_W-1:0] col,
                          logic [FIELD_W-1:0] row, logic cell_in);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 18) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.op      <= op;
    req_ch.col     <= col;
    req_ch.row     <= row;
    req_ch.cell_in <= cell_in;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_ca_request(op, col, row, cell_in);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_BOUNDARY: boundary = bnd_t'(data[0]);
      CFG_SHAPE:    shape = shape_t'(data[0]);
      CFG_BIRTH:    birth = data[MASK_W-1:0];
      CFG_SURVIVE:  survive = data[MASK_W-1:0];
      CFG_WIDTH:    grid_w = data[SIZE_W-1:0];
      CFG_HEIGHT:   grid_h = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_rules(logic [CFG_DATA_W-1:0] bnd, logic [CFG_DATA_W-1:0] shp,
                           logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] s,
                           logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    write_cfg(CFG_BOUNDARY, bnd);
    write_cfg(CFG_SHAPE, shp);
    write_cfg(CFG_BIRTH, b);
    write_cfg(CFG_SURVIVE, s);
    write_cfg(CFG_WIDTH, w);
    write_cfg(CFG_HEIGHT, h);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  task automatic test_wrap_blinker();
    send_req(OP_WRITE, 0, 0, 1'b1);
    send_req(OP_WRITE, 63, 63, 1'b1);
    send_req(OP_READ, 0, 0, 1'b0);
    send_req(OP_READ, 63, 63, 1'b0);
    send_req(OP_WRITE, 0, 0, 1'b0);
    send_req(OP_WRITE, 63, 63, 1'b0);
    // horizontal blinker across the right edge of the last row
    send_req(OP_WRITE, 62, 63, 1'b1);
    send_req(OP_WRITE, 63, 63, 1'b1);
    send_req(OP_WRITE, 0, 63, 1'b1);
    send_req(OP_STEP, 0, 0, 1'b0);
    send_req(OP_READ, 63, 0, 1'b0);
    send_req(OP_READ, 0, 63, 1'b0);
    send_req(OP_UNUSED, 63, 63, 1'b1);
    send_req(OP_STEP, 63, 63, 1'b1);
    send_req(OP_WRITE, 20, 20, 1'b1);
  endtask

  task automatic test_grid_sizes();
    wait_idle();
    set_rules(CFG_DATA_W'(BND_DEAD), CFG_DATA_W'(SHAPE_VN), 9'd0, 9'h1FF, 9'd0, 9'd5);
    send_req(OP_WRITE, 0, 0, 1'b1);
    send_req(OP_READ, 0, 0, 1'b0);
    send_req(OP_STEP, 0, 0, 1'b0);
    wait_idle();
    // single cell on a wrapped grid is its own neighbor eight times
    set_rules(CFG_DATA_W'(BND_WRAP), CFG_DATA_W'(SHAPE_MOORE), 9'h1FF, 9'h100, 9'd1, 9'd1);
    send_req(OP_WRITE, 0, 0, 1'b1);
    send_req(OP_STEP, 0, 0, 1'b0);
    send_req(OP_READ, 5, 0, 1'b0);
    wait_idle();
    set_rules(CFG_DATA_W'(BND_WRAP), CFG_DATA_W'(SHAPE_VN), 9'h004, 9'h010, 9'd2, 9'd2);
    send_req(OP_WRITE, 1, 1, 1'b1);
    send_req(OP_STEP, 0, 0, 1'b0);
    send_req(OP_READ, 1, 0, 1'b0);
    wait_idle();
    // oversized sizes saturate; the cell left outside the small grids comes back
    set_rules(CFG_DATA_W'(BND_DEAD), CFG_DATA_W'(SHAPE_MOORE), 9'd8, 9'd12, 9'h1E4, 9'd127);
    send_req(OP_READ, 20, 20, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_rules(CFG_DATA_W'(BND_WRAP), CFG_DATA_W'(SHAPE_MOORE), 9'd8, 9'd12, 9'd8, 9'd8);
    for (int i = 0; i < 6; i++)
      send_req(OP_WRITE, FIELD_W'($urandom_range(7)), FIELD_W'($urandom_range(7)), 1'b1);
    // hold the result side while requests keep coming
    stall_left = 300;
    for (int i = 0; i < 10; i++)
      send_req(OP_READ, FIELD_W'($urandom_range(7)), FIELD_W'($urandom_range(7)), 1'b0);
    send_req(OP_STEP, 0, 0, 1'b0);
    wait_idle();
    no_idle = 1'b1;
    for (int i = 0; i < 12; i++)
      send_req((i % 3 == 2) ? OP_STEP : OP_READ, FIELD_W'($urandom_range(7)),
               FIELD_W'($urandom_range(7)), 1'b0);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_rules();
    int done_items, phase, uw, uh;
    logic [SIZE_W-1:0] w, h;
    done_items = 0;
    phase = 0;
    while (done_items < 90) begin
      wait_idle();
      no_idle = (phase == 2);
      case ($urandom_range(9))
        0:       w = '0;
        1:       w = SIZE_W'($urandom_range(127, 64));
        2:       w = 1;
        default: w = SIZE_W'($urandom_range(12, 2));
      endcase
      if (w > 12) begin
        h = SIZE_W'($urandom_range(3, 1));
      end else begin
        case ($urandom_range(9))
          0:       h = '0;
          1:       h = SIZE_W'($urandom_range(127, 64));
          2:       h = 1;
          default: h = SIZE_W'($urandom_range(12, 2));
        endcase
      end
      set_rules(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), pick_mask(), pick_mask(),
                {2'($urandom_range(3)), w}, {2'($urandom_range(3)), h});
      uw = span(w, GRID_COLS);
      uh = span(h, GRID_ROWS);
      // seed a pattern, then evolve it with reads in between
      repeat ($urandom_range(10, 2)) begin
        if (uw > 0 && uh > 0) begin
          send_req(OP_WRITE, FIELD_W'($urandom_range(uw - 1)),
                   FIELD_W'($urandom_range(uh - 1)), $urandom_range(3) != 0);
          done_items++;
        end else begin
          send_req(OP_WRITE, FIELD_W'($urandom), FIELD_W'($urandom), 1'b1);
        end
      end
      repeat ($urandom_range(4, 1)) begin
        send_req(OP_STEP, FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom));
        done_items++;
        repeat ($urandom_range(3)) begin
          if (uw > 0 && uh > 0)
            send_req(OP_READ, FIELD_W'($urandom_range(uw - 1)),
                     FIELD_W'($urandom_range(uh - 1)), 1'b0);
          else
            send_req(OP_READ, FIELD_W'($urandom), FIELD_W'($urandom), 1'b0);
          done_items++;
        end
        if ($urandom_range(4) == 0)
          send_req(OP_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom));
      end
      phase++;
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    int guard;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_WRITE;
    req_ch.col     = '0;
    req_ch.row     = '0;
    req_ch.cell_in = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_BOUNDARY;
    cfg_ch.data    = '0;
    grid        = '{default: '{default: 1'b0}};
    gen_counter = '0;
    boundary    = BND_WRAP;
    shape       = SHAPE_MOORE;
    birth       = BIRTH_RST;
    survive     = SURVIVE_RST;
    grid_w      = SIZE_RST;
    grid_h      = SIZE_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_wrap_blinker();
    test_grid_sizes();
    test_backpressure();
    test_random_rules();

    guard = 0;
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("results never returned", GEN_W'(due_results.size()), '0);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
